[hdl/jsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// types, codes and character constants for the json string unescaper
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef logic [2:0] phase_type;
   typedef logic [1:0] status_type;
   typedef logic [7:0] byte_type;
   typedef logic [3:0] nibble_type;

   localparam phase_type PH_IDLE = 3'd0;
   localparam phase_type PH_BODY = 3'd1;
   localparam phase_type PH_ESC  = 3'd2;
   localparam phase_type PH_U1   = 3'd3;
   localparam phase_type PH_U2   = 3'd4;
   localparam phase_type PH_U3   = 3'd5;
   localparam phase_type PH_U4   = 3'd6;

   localparam status_type ST_DATA  = 2'd0;
   localparam status_type ST_CLOSE = 2'd1;
   localparam status_type ST_NOQ   = 2'd2;
   localparam status_type ST_UNTRM = 2'd3;

   localparam byte_type CH_NUL   = 8'h00;
   localparam byte_type CH_QUOTE = 8'h22;
   localparam byte_type CH_BSL   = 8'h5c;
   localparam byte_type CH_N     = 8'h6e;
   localparam byte_type CH_R     = 8'h72;
   localparam byte_type CH_T     = 8'h74;
   localparam byte_type CH_B     = 8'h62;
   localparam byte_type CH_F     = 8'h66;
   localparam byte_type CH_U     = 8'h75;
   localparam byte_type CH_LF    = 8'h0a;
   localparam byte_type CH_CR    = 8'h0d;
   localparam byte_type CH_TAB   = 8'h09;
   localparam byte_type CH_BS    = 8'h08;
   localparam byte_type CH_FF    = 8'h0c;
   localparam byte_type CH_0     = 8'h30;
   localparam byte_type CH_9     = 8'h39;
   localparam byte_type CH_UA    = 8'h41;
   localparam byte_type CH_UF    = 8'h46;
   localparam byte_type CH_LA    = 8'h61;
   localparam byte_type CH_LF_HEX = 8'h66;

   // non-hex characters count as zero
   function automatic nibble_type hex_nibble(input byte_type c);
      byte_type d;
      begin
         d = 8'd0;
         if (c >= CH_0 && c <= CH_9) begin
            d = c - CH_0;
         end else if (c >= CH_UA && c <= CH_UF) begin
            d = c - CH_UA + 8'd10;
         end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            d = c - CH_LA + 8'd10;
         end
         return d[3:0];
      end
   endfunction

endpackage

[hdl/json_string_unescape_top.sv]
`timescale 1ns / 1ps
// path: input register, then output register that drives the rsp channel
// throughput: one item per cycle; only a stalled result held in the output
// register backs up into the one-item input register
// reset: synchronous, active high; clears valids, phase and held nibble
// ----------------------------------------------------------------------------
// json_string_unescape_top
// streaming unescaper for one quoted json string literal, one byte per item
// ----------------------------------------------------------------------------
module json_string_unescape_top
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_last
);

   logic       in_valid_ff;
   byte_type   in_byte_ff;
   phase_type  phase_ff, phase_in;
   nibble_type nib_ff, nib_in;
   logic       out_valid_ff, out_valid_in;
   byte_type   out_byte_ff, out_byte_in;
   status_type out_status_ff, out_status_in;
   logic       out_last_ff, out_last_in;
   logic       emit;
   logic       move;

   assign move      = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !move;

   always_comb begin
      phase_in      = phase_ff;
      nib_in        = nib_ff;
      emit          = 1'b0;
      out_byte_in   = CH_NUL;
      out_status_in = ST_DATA;
      out_last_in   = 1'b0;
      if (phase_ff >= PH_BODY && phase_ff <= PH_U4 && in_byte_ff == CH_NUL) begin
         phase_in      = PH_IDLE;
         nib_in        = 4'd0;
         emit          = 1'b1;
         out_status_in = ST_UNTRM;
         out_last_in   = 1'b1;
      end else begin
         case (phase_ff)
            PH_BODY: begin
               if (in_byte_ff == CH_QUOTE) begin
                  phase_in      = PH_IDLE;
                  emit          = 1'b1;
                  out_status_in = ST_CLOSE;
                  out_last_in   = 1'b1;
               end else if (in_byte_ff == CH_BSL) begin
                  phase_in = PH_ESC;
               end else begin
                  emit        = 1'b1;
                  out_byte_in = in_byte_ff;
               end
            end
            PH_ESC: begin
               phase_in    = PH_BODY;
               emit        = 1'b1;
               out_byte_in = in_byte_ff;
               case (in_byte_ff)
                  CH_N: out_byte_in = CH_LF;
                  CH_R: out_byte_in = CH_CR;
                  CH_T: out_byte_in = CH_TAB;
                  CH_B: out_byte_in = CH_BS;
                  CH_F: out_byte_in = CH_FF;
                  CH_U: begin
                     phase_in = PH_U1;
                     emit     = 1'b0;
                  end
                  default: out_byte_in = in_byte_ff;
               endcase
            end
            PH_U1, PH_U3: begin
               nib_in   = hex_nibble(in_byte_ff);
               phase_in = (phase_ff == PH_U1) ? PH_U2 : PH_U4;
            end
            PH_U2, PH_U4: begin
               emit        = 1'b1;
               out_byte_in = {nib_ff, hex_nibble(in_byte_ff)};
               phase_in    = (phase_ff == PH_U2) ? PH_U3 : PH_BODY;
            end
            default: begin
               if (in_byte_ff == CH_QUOTE) begin
                  phase_in = PH_BODY;
               end else begin
                  phase_in      = PH_IDLE;
                  emit          = 1'b1;
                  out_status_in = ST_NOQ;
                  out_last_in   = 1'b1;
               end
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && rsp_stall;
      if (move) begin
         out_valid_in = emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         nib_ff       <= 4'd0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         out_valid_ff <= out_valid_in;
         if (move) begin
            phase_ff <= phase_in;
            nib_ff   <= nib_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_byte_ff <= req_in_byte;
      end
      if (move && emit) begin
         out_byte_ff   <= out_byte_in;
         out_status_ff <= out_status_in;
         out_last_ff   <= out_last_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last     = out_last_ff;

`ifndef SYNTH
   a_last_iff_not_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_status != ST_DATA)))
      else $error("last flag does not match status");

   a_end_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_byte == CH_NUL)
      else $error("close or error item carries nonzero byte");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_U4)
      else $error("phase holds unused code");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");
`endif

endmodule

[bench/jsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_checker
// watches the req and rsp channels of the json string unescaper, decodes each
// accepted byte with its own copy of the escape state, and compares every
// result item in order against the oldest decoded byte still waiting
// ----------------------------------------------------------------------------
module jsu_checker
   import jsu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic [1:0] rsp_status,
   input  logic       rsp_last,
   output int         decoded_pending,
   output int         mismatch_count
);

   typedef struct packed {
      byte_type   out_byte;
      status_type status;
      logic       last;
   } decoded_type;

   decoded_type decoded_fifo[$];
   phase_type   phase;
   nibble_type  held_nibble;

   initial begin
      decoded_pending = 0;
      mismatch_count = 0;
      phase = PH_IDLE;
      held_nibble = 4'd0;
   end

   function automatic nibble_type nibble_value(input byte_type c);
      byte_type folded;
      folded = c | 8'h20;
      if (c >= CH_0 && c <= CH_9) begin
         return c[3:0];
      end else if (folded >= CH_LA && folded <= CH_LF_HEX) begin
         return c[3:0] + 4'd9;
      end
      return 4'd0;
   endfunction

   // advances the escape state by one byte, returns 1 when a result is due
   function automatic bit unescape_byte(input byte_type b, output decoded_type r);
      bit produced;
      produced = 1'b1;
      r.out_byte = b;
      r.status = ST_DATA;
      r.last = 1'b0;
      if (phase != PH_IDLE && phase <= PH_U4 && b == CH_NUL) begin
         r.out_byte = CH_NUL;
         r.status = ST_UNTRM;
         r.last = 1'b1;
         phase = PH_IDLE;
         held_nibble = 4'd0;
      end else begin
         case (phase)
            PH_BODY: begin
               if (b == CH_QUOTE) begin
                  r.out_byte = CH_NUL;
                  r.status = ST_CLOSE;
                  r.last = 1'b1;
                  phase = PH_IDLE;
               end else if (b == CH_BSL) begin
                  produced = 1'b0;
                  phase = PH_ESC;
               end
            end
            PH_ESC: begin
               phase = PH_BODY;
               case (b)
                  CH_N: r.out_byte = CH_LF;
                  CH_R: r.out_byte = CH_CR;
                  CH_T: r.out_byte = CH_TAB;
                  CH_B: r.out_byte = CH_BS;
                  CH_F: r.out_byte = CH_FF;
                  CH_U: begin
                     produced = 1'b0;
                     phase = PH_U1;
                  end
                  default: ;
               endcase
            end
            PH_U1, PH_U3: begin
               produced = 1'b0;
               held_nibble = nibble_value(b);
               phase = phase + 3'd1;
            end
            PH_U2, PH_U4: begin
               r.out_byte = {held_nibble, nibble_value(b)};
               phase = (phase == PH_U2) ? PH_U3 : PH_BODY;
            end
            default: begin
               if (b == CH_QUOTE) begin
                  produced = 1'b0;
                  phase = PH_BODY;
               end else begin
                  r.out_byte = CH_NUL;
                  r.status = ST_NOQ;
                  r.last = 1'b1;
                  phase = PH_IDLE;
               end
            end
         endcase
      end
      return produced;
   endfunction

   always @(posedge clock) begin : watch
      decoded_type want;
      decoded_type got;
      if (reset) begin
         decoded_fifo.delete();
         phase = PH_IDLE;
         held_nibble = 4'd0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.out_byte = rsp_out_byte;
            got.status = rsp_status;
            got.last = rsp_last;
            if (decoded_fifo.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected result byte %h status %0d last %0d",
                           $realtime, got.out_byte, got.status, got.last);
               end
            end else begin
               want = decoded_fifo.pop_front();
               if (got.out_byte != want.out_byte || got.status != want.status ||
                   got.last != want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch expected byte %h status %0d last %0d, got %h %0d %0d",
                              $realtime, want.out_byte, want.status, want.last,
                              got.out_byte, got.status, got.last);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (unescape_byte(req_in_byte, want)) begin
               decoded_fifo.push_back(want);
            end
         end
      end
      decoded_pending <= decoded_fifo.size();
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives quoted string literals through the json string unescaper: a short
// directed run of edge cases, then mostly well-formed random literals mixed
// with cut-off and unquoted ones, under random idling on both channels
// ----------------------------------------------------------------------------
module testbench;
   import jsu_pkg::*;

   localparam int       QUIET_LIMIT = 2000;
   localparam int       ITEM_TARGET = 1400;
   localparam int       HOLD_CYCLES = 60;
   localparam byte_type CH_SLASH    = 8'h2f;
   localparam byte_type CH_UG       = 8'h47;
   localparam byte_type CH_1        = 8'h31;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_status;
   logic       rsp_last;

   int         decoded_pending;
   int         mismatch_count;
   int         quiet_cycles;
   int         sent_bytes;
   logic       no_idle;
   logic       hold_req;
   byte_type   literal_text[$];

   json_string_unescape_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_status   (rsp_status),
      .rsp_last     (rsp_last)
   );

   jsu_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .decoded_pending (decoded_pending),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      bit hold_served;
      hold_served = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_served) begin
            hold_served = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= !no_idle && ($urandom_range(99) < 22);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input byte_type b);
      while (!no_idle && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic send_text();
      foreach (literal_text[i]) send_byte(literal_text[i]);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (decoded_pending != 0) @(posedge clock);
   endtask

   task automatic build_literal();
      int       segments;
      int       pick;
      byte_type c;
      literal_text.delete();
      literal_text.push_back(CH_QUOTE);
      segments = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
      repeat (segments) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            do c = byte_type'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSL);
            literal_text.push_back(c);
         end else if (pick < 85) begin
            literal_text.push_back(CH_BSL);
            case ($urandom_range(8))
               0: c = CH_N;
               1: c = CH_R;
               2: c = CH_T;
               3: c = CH_B;
               4: c = CH_F;
               5: c = CH_QUOTE;
               6: c = CH_BSL;
               7: c = CH_SLASH;
               default: begin
                  // unknown escape letter passes through
                  do c = byte_type'($urandom_range(1, 255)); while (c == CH_U);
               end
            endcase
            literal_text.push_back(c);
         end else begin
            literal_text.push_back(CH_BSL);
            literal_text.push_back(CH_U);
            repeat (4) begin
               pick = $urandom_range(21);
               if (pick < 10) begin
                  c = byte_type'(CH_0 + pick);
               end else if (pick < 16) begin
                  c = byte_type'(CH_LA + (pick - 10));
               end else if (pick < 20) begin
                  c = byte_type'(CH_UA + $urandom_range(5));
               end else begin
                  c = byte_type'($urandom_range(1, 255));
               end
               literal_text.push_back(c);
            end
         end
      end
      literal_text.push_back(CH_QUOTE);
   endtask

   initial begin : stimulus
      int       kind;
      int       cut;
      bit       drained;
      byte_type c;
      reset = 1'b1;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      no_idle = 1'b0;
      hold_req = 1'b0;
      sent_bytes = 0;
      quiet_cycles = 0;
      drained = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // idle bytes, plain extremes, escapes, hex with non-hex digits and a
      // quote taken as a digit, then zero bytes in body, escape and hex
      literal_text = '{CH_NUL, 8'hff, CH_QUOTE, 8'h01, 8'hff, CH_BSL, CH_N,
                       CH_BSL, CH_T, CH_BSL, CH_U, CH_LA, CH_UF, CH_UG, CH_QUOTE,
                       CH_QUOTE, CH_QUOTE, CH_BSL, CH_NUL, CH_QUOTE, CH_BSL, CH_U,
                       CH_1, CH_NUL, CH_QUOTE, CH_NUL};
      send_text();

      while (sent_bytes < ITEM_TARGET) begin
         no_idle <= (sent_bytes >= 600 && sent_bytes < 850);
         if (!hold_req && sent_bytes >= 300) begin
            hold_req <= 1'b1;
         end
         if (!drained && sent_bytes >= 1000) begin
            drained = 1'b1;
            wait_drained();
         end
         build_literal();
         kind = $urandom_range(99);
         if (kind < 8) begin
            // cut short by a zero byte
            cut = $urandom_range(1, literal_text.size() - 1);
            while (literal_text.size() > cut + 1) literal_text.delete(literal_text.size() - 1);
            literal_text[cut] = CH_NUL;
         end else if (kind < 14) begin
            // stray bytes before the opening quote
            repeat ($urandom_range(1, 3)) begin
               do c = byte_type'($urandom_range(0, 255)); while (c == CH_QUOTE);
               literal_text.push_front(c);
            end
         end
         send_text();
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
